// ===== hdl/frie_pkg.sv =====
// Package for the four-register instruction execute unit.
// Holds widths, opcodes, controller states and the control/status structs.
// No dependencies.
package frie_pkg;

    localparam int DATA_W        = 32;
    localparam int PROGRAM_DEPTH = 1024;
    localparam int PC_W          = $clog2(PROGRAM_DEPTH + 1);
    localparam int TARGET_W      = $clog2(PROGRAM_DEPTH);
    localparam int OP_W          = 4;
    localparam int REG_IDX_W     = 2;
    localparam int DIV_CNT_W     = $clog2(DATA_W);

    localparam logic [PC_W-1:0] PROGRAM_DEPTH_C = PC_W'(PROGRAM_DEPTH);

    // Instruction opcodes; codes 14 and 15 are no-operations.
    typedef enum logic [OP_W-1:0] {
        OP_MOV   = 4'd0,
        OP_READ  = 4'd1,
        OP_ADD   = 4'd2,
        OP_SUB   = 4'd3,
        OP_MUL   = 4'd4,
        OP_DIV   = 4'd5,
        OP_PRINT = 4'd6,
        OP_JMP   = 4'd7,
        OP_JE    = 4'd8,
        OP_JNE   = 4'd9,
        OP_JG    = 4'd10,
        OP_JGE   = 4'd11,
        OP_JL    = 4'd12,
        OP_JLE   = 4'd13
    } frie_op_t;

    // Register indexes of the four general registers.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_A = 2'd0,
        REG_B = 2'd1,
        REG_C = 2'd2,
        REG_D = 2'd3
    } frie_reg_idx_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_DIV  = 2'd2
    } frie_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic div_start;
        logic div_commit;
    } frie_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic halted_now;
        logic is_div;
        logic div_zero;
        logic div_done;
    } frie_status_t;

endpackage

// ===== hdl/frie_if.sv =====
// Channel interfaces of the four-register instruction execute unit:
// the instruction channel and the result channel, each with valid/ready.
// Depends on frie_pkg.
interface frie_in_if;
    import frie_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      action;
    logic                 first_is_reg;
    logic [REG_IDX_W-1:0] first_reg;
    logic [DATA_W-1:0]    first_imm;
    logic                 second_is_reg;
    logic [REG_IDX_W-1:0] second_reg;
    logic [DATA_W-1:0]    second_imm;
    logic [REG_IDX_W-1:0] dest_reg;
    logic [TARGET_W-1:0]  jump_target;
    logic [DATA_W-1:0]    read_value;

    modport source (
        output valid, action, first_is_reg, first_reg, first_imm, second_is_reg,
               second_reg, second_imm, dest_reg, jump_target, read_value,
        input  ready
    );
    modport sink (
        input  valid, action, first_is_reg, first_reg, first_imm, second_is_reg,
               second_reg, second_imm, dest_reg, jump_target, read_value,
        output ready
    );
endinterface

interface frie_out_if;
    import frie_pkg::*;

    logic              valid;
    logic              ready;
    logic [PC_W-1:0]   next_pc;
    logic              halted;
    logic              print_valid;
    logic [DATA_W-1:0] print_value;
    logic              divide_by_zero;

    modport source (
        output valid, next_pc, halted, print_valid, print_value, divide_by_zero,
        input  ready
    );
    modport sink (
        input  valid, next_pc, halted, print_valid, print_value, divide_by_zero,
        output ready
    );
endinterface

// ===== hdl/frie_divider.sv =====
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
// Used by the datapath for the div instruction. Depends on frie_pkg.
module frie_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [frie_pkg::DATA_W-1:0] dividend,
    input  logic [frie_pkg::DATA_W-1:0] divisor,
    output logic                       done,
    output logic [frie_pkg::DATA_W-1:0] quotient
);
    import frie_pkg::*;

    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic                 neg_reg, neg_next;
    logic [DATA_W:0]      shifted;
    logic [DATA_W:0]      diff;

    // One restoring step on the magnitudes, plus start and finish control.
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DATA_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            dvs_next = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
            neg_next = dividend[DATA_W-1] ^ divisor[DATA_W-1];
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!diff[DATA_W])
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == '1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // Apply the sign; the most negative over minus one wraps to itself.
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign done     = done_reg;

endmodule

// ===== hdl/frie_datapath.sv =====
// Datapath: register file a..d, program counter, program length, the
// operand latches, the ALU, the divider and the result register.
// Depends on frie_pkg, frie_if and frie_divider.
module frie_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [frie_pkg::PC_W-1:0]  cfg_wdata,
    frie_in_if.sink                    instr,
    frie_out_if.source                 result,
    input  frie_pkg::frie_cmd_t        cmd,
    output frie_pkg::frie_status_t     status
);
    import frie_pkg::*;

    // Architectural state.
    logic [DATA_W-1:0] ra_reg, rb_reg, rc_reg, rd_reg;
    logic [PC_W-1:0]   pc_reg;
    logic [PC_W-1:0]   len_reg;

    // Latched instruction with its operands resolved.
    logic [OP_W-1:0]      act_reg;
    logic [DATA_W-1:0]    src_reg;
    logic [DATA_W-1:0]    sec_reg;
    logic [DATA_W-1:0]    dv_reg;
    logic [REG_IDX_W-1:0] dst_reg;
    logic [TARGET_W-1:0]  tgt_reg;
    logic [DATA_W-1:0]    rdv_reg;

    // Result register.
    logic              out_valid_reg;
    logic [PC_W-1:0]   out_pc_reg;
    logic              out_halt_reg;
    logic              out_pvalid_reg;
    logic [DATA_W-1:0] out_pvalue_reg;
    logic              out_dz_reg;

    logic [PC_W-1:0]   len_eff;
    logic              halted_now;
    logic              take;
    logic              wr_en;
    logic [DATA_W-1:0] wr_val;
    logic [PC_W-1:0]   npc;
    logic              pvalid;
    logic [DATA_W-1:0] pvalue;
    logic              dz;
    logic              commit;
    logic              div_done;
    logic [DATA_W-1:0] quotient;

    function automatic logic [DATA_W-1:0] pick_reg(
        input logic [REG_IDX_W-1:0] idx,
        input logic [DATA_W-1:0]    a,
        input logic [DATA_W-1:0]    b,
        input logic [DATA_W-1:0]    c,
        input logic [DATA_W-1:0]    d
    );
        logic [DATA_W-1:0] v;
        case (frie_reg_idx_t'(idx))
            REG_A:   v = a;
            REG_B:   v = b;
            REG_C:   v = c;
            REG_D:   v = d;
            default: v = a;
        endcase
        return v;
    endfunction

    // Program length clamped to the program store depth.
    assign len_eff    = (len_reg > PROGRAM_DEPTH_C) ? PROGRAM_DEPTH_C : len_reg;
    assign halted_now = (pc_reg >= len_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= '0;
        else if (cfg_we)
            len_reg <= cfg_wdata;
    end

    // Capture the instruction word and read its operands.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= instr.action;
            src_reg <= instr.first_is_reg
                       ? pick_reg(instr.first_reg, ra_reg, rb_reg, rc_reg, rd_reg)
                       : instr.first_imm;
            sec_reg <= instr.second_is_reg
                       ? pick_reg(instr.second_reg, ra_reg, rb_reg, rc_reg, rd_reg)
                       : instr.second_imm;
            dv_reg  <= pick_reg(instr.dest_reg, ra_reg, rb_reg, rc_reg, rd_reg);
            dst_reg <= instr.dest_reg;
            tgt_reg <= instr.jump_target;
            rdv_reg <= instr.read_value;
        end
    end

    frie_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (src_reg),
        .divisor  (dv_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Execute: register write-back, next pc and result flags.
    always_comb
    begin
        take   = 1'b0;
        wr_en  = 1'b0;
        wr_val = '0;
        pvalid = 1'b0;
        pvalue = '0;
        dz     = 1'b0;
        npc    = pc_reg + 1'b1;
        if (cmd.div_commit)
        begin
            wr_en  = 1'b1;
            wr_val = quotient;
        end
        else if (halted_now)
        begin
            npc = pc_reg;
        end
        else
        begin
            case (frie_op_t'(act_reg))
                OP_MOV:
                begin
                    wr_en  = 1'b1;
                    wr_val = src_reg;
                end
                OP_READ:
                begin
                    wr_en  = 1'b1;
                    wr_val = rdv_reg;
                end
                OP_ADD:
                begin
                    wr_en  = 1'b1;
                    wr_val = dv_reg + src_reg;
                end
                OP_SUB:
                begin
                    wr_en  = 1'b1;
                    wr_val = dv_reg - src_reg;
                end
                OP_MUL:
                begin
                    wr_en  = 1'b1;
                    wr_val = dv_reg * src_reg;
                end
                OP_DIV:   dz = (dv_reg == '0);
                OP_PRINT:
                begin
                    pvalid = 1'b1;
                    pvalue = src_reg;
                end
                OP_JMP:   take = 1'b1;
                OP_JE:    take = (src_reg == sec_reg);
                OP_JNE:   take = (src_reg != sec_reg);
                OP_JG:    take = ($signed(src_reg) >  $signed(sec_reg));
                OP_JGE:   take = ($signed(src_reg) >= $signed(sec_reg));
                OP_JL:    take = ($signed(src_reg) <  $signed(sec_reg));
                OP_JLE:   take = ($signed(src_reg) <= $signed(sec_reg));
                default:  take = 1'b0;
            endcase
            if (take)
                npc = {1'b0, tgt_reg};
        end
    end

    assign commit = cmd.exec | cmd.div_commit;

    // Register file and program counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ra_reg <= '0;
            rb_reg <= '0;
            rc_reg <= '0;
            rd_reg <= '0;
            pc_reg <= '0;
        end
        else if (commit)
        begin
            pc_reg <= npc;
            if (wr_en)
            begin
                case (frie_reg_idx_t'(dst_reg))
                    REG_A:   ra_reg <= wr_val;
                    REG_B:   rb_reg <= wr_val;
                    REG_C:   rc_reg <= wr_val;
                    REG_D:   rd_reg <= wr_val;
                    default: ra_reg <= ra_reg;
                endcase
            end
        end
    end

    // Result word valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (commit)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    // Result word payload.
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_pc_reg     <= npc;
            out_halt_reg   <= (npc >= len_eff);
            out_pvalid_reg <= pvalid;
            out_pvalue_reg <= pvalue;
            out_dz_reg     <= dz;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.next_pc        = out_pc_reg;
    assign result.halted         = out_halt_reg;
    assign result.print_valid    = out_pvalid_reg;
    assign result.print_value    = out_pvalue_reg;
    assign result.divide_by_zero = out_dz_reg;

    // Status towards the controller.
    assign status.out_free   = !out_valid_reg || result.ready;
    assign status.halted_now = halted_now;
    assign status.is_div     = (act_reg == OP_DIV);
    assign status.div_zero   = (dv_reg == '0);
    assign status.div_done   = div_done;

endmodule

// ===== hdl/frie_ctrl.sv =====
// Controller state machine: sequences capture, execution and division.
// Depends on frie_pkg.
module frie_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  frie_pkg::frie_status_t status,
    output frie_pkg::frie_cmd_t    cmd
);
    import frie_pkg::*;

    frie_state_t state_reg, state_next;
    logic        long_div;

    // A division that really runs the divider: not halted, nonzero divisor.
    assign long_div = !status.halted_now && status.is_div && !status.div_zero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && status.out_free)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (long_div)
                    state_next = S_DIV;
                else
                    state_next = S_IDLE;
            end
            S_DIV:
            begin
                if (status.div_done)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = status.out_free;
                cmd.load = in_valid && status.out_free;
            end
            S_EXEC:
            begin
                cmd.div_start = long_div;
                cmd.exec      = !long_div;
            end
            S_DIV:
            begin
                cmd.div_commit = status.div_done;
            end
            default: in_ready = 1'b0;
        endcase
    end

endmodule

// ===== hdl/four_register_instruction_execute_unit.sv =====
// Four-register instruction execute unit: top level joining controller and datapath.
// Depends on frie_pkg, frie_if, frie_ctrl and frie_datapath.
//
// Each instruction word is captured, then executed, before the
// next one is accepted; a div with a nonzero divisor and a running program
// also runs the iterative divider, which retires one quotient bit
// per cycle. The result word sits in an output register, so a new
// instruction is taken in the same cycle as a waiting result is collected.
// program_length may be written at any time the unit is idle; values above
// 1024 act as 1024, and a program counter at or past it halts the machine.
module four_register_instruction_execute_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [frie_pkg::PC_W-1:0] cfg_wdata,
    frie_in_if.sink                   instr,
    frie_out_if.source                result
);
    import frie_pkg::*;

    frie_cmd_t    cmd;
    frie_status_t status;
    logic         in_ready;

    assign instr.ready = in_ready;

    // Controller.
    frie_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (instr.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    frie_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .instr     (instr),
        .result    (result),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
